### rtl/core/rwtm_pkg.sv
// ----------------------------------------------------------------------------
// rwtm_pkg: shared types and constants for the wall texel mapper
// Word formats, configuration register indexes and divider sizes.
// ----------------------------------------------------------------------------
package rwtm_pkg;

  // The row lane divides 2n+h by 2h with a restoring divider. The column lane
  // divides (tw-1)f+5000 by 10000 through a reciprocal multiply. Both
  // quotients stay below 2^QW.
  localparam int ROW_NW = 27;
  localparam int ROW_DW = 17;
  localparam int COL_NW = 24;
  localparam int QW     = 11;

  // 10000 is 16 times 625; the reciprocal of 625 scaled by 2^30, rounded up,
  // is exact for every dividend the column lane can see.
  localparam int                     COL_RECIP_W = 21;
  localparam logic [COL_RECIP_W-1:0] COL_RECIP   = 21'd1717987;
  localparam int                     COL_SHIFT   = 30;

  localparam logic [1:0] KIND_CEILING = 2'd0;
  localparam logic [1:0] KIND_FLOOR   = 2'd1;
  localparam logic [1:0] KIND_WALL    = 2'd2;

  localparam logic [2:0] REG_SCREEN_HEIGHT   = 3'd0;
  localparam logic [2:0] REG_CEILING_COLOR   = 3'd1;
  localparam logic [2:0] REG_FLOOR_COLOR     = 3'd2;
  localparam logic [2:0] REG_TEXTURE_WIDTHS  = 3'd3;
  localparam logic [2:0] REG_TEXTURE_HEIGHTS = 3'd4;

  localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [15:0] wall_height;
    logic [1:0]  texture_select;
    logic [13:0] hit_fraction;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  pixel_kind;
    logic [23:0] fill_color;
    logic [1:0]  texel_texture;
    logic [9:0]  texel_row;
    logic [9:0]  texel_column;
    logic [19:0] texel_offset;
    logic        height_fault;
  } out_word_t;

  typedef struct packed {
    logic [12:0] screen_height;
    logic [23:0] ceiling_color;
    logic [23:0] floor_color;
    logic [43:0] texture_widths;
    logic [43:0] texture_heights;
  } cfg_regs_t;

  // Per-pixel attributes that ride alongside the arithmetic.
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] fill;
    logic [1:0]  sel;
    logic        fault;
    logic [9:0]  thm1;
    logic [9:0]  twm1;
    logic [10:0] tw;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [15:0] rt;
    logic [15:0] h;
    logic [13:0] f;
  } cls_word_t;

  typedef struct packed {
    side_t             side;
    logic [ROW_NW-1:0] row_n;
    logic [ROW_DW-1:0] row_d;
    logic [COL_NW-1:0] col_n;
  } num_word_t;

  typedef struct packed {
    side_t         side;
    logic [QW-1:0] row_q;
    logic [QW-1:0] col_q;
  } div_word_t;

endpackage

### rtl/core/raycast_wall_texel_mapper_core.sv
// Each word passes the classify, numerator, divider, multiply and result registers.
// Throughput: one word per cycle; the 11-stage restoring divider for the texel row
// sets the depth, and every stage takes a new word each cycle.
// A stall at the output freezes the whole pipeline in place.
// Reset clears all stage valid bits and loads the register defaults
// (screen height 480, colors and texture sizes zero).
// ----------------------------------------------------------------------------
// raycast_wall_texel_mapper_core: pixel to ceiling, floor or texel mapper
// Holds the configuration registers and chains the pipeline stages.
// ----------------------------------------------------------------------------
module raycast_wall_texel_mapper_core #(
  parameter int TEXTURE_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [43:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rwtm_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rwtm_pkg::out_word_t  out_word
);

  rwtm_pkg::cfg_regs_t cfg;
  logic                en;
  logic                cls_valid;
  rwtm_pkg::cls_word_t cls_word;
  logic                num_valid;
  rwtm_pkg::num_word_t num_word;
  logic                div_valid;
  rwtm_pkg::div_word_t div_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_height   <= rwtm_pkg::SCREEN_HEIGHT_RESET;
      cfg.ceiling_color   <= 24'd0;
      cfg.floor_color     <= 24'd0;
      cfg.texture_widths  <= 44'd0;
      cfg.texture_heights <= 44'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rwtm_pkg::REG_SCREEN_HEIGHT:   cfg.screen_height   <= cfg_data[12:0];
        rwtm_pkg::REG_CEILING_COLOR:   cfg.ceiling_color   <= cfg_data[23:0];
        rwtm_pkg::REG_FLOOR_COLOR:     cfg.floor_color     <= cfg_data[23:0];
        rwtm_pkg::REG_TEXTURE_WIDTHS:  cfg.texture_widths  <= cfg_data;
        rwtm_pkg::REG_TEXTURE_HEIGHTS: cfg.texture_heights <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the result register is empty or being taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rwtm_classify #(
    .TEXTURE_COUNT (TEXTURE_COUNT)
  ) u_classify (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .valid_in (in_valid),
    .word_in  (in_word),
    .valid    (cls_valid),
    .word     (cls_word)
  );

  rwtm_numer u_numer (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (cls_valid),
    .word_in  (cls_word),
    .valid    (num_valid),
    .word     (num_word)
  );

  rwtm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (num_valid),
    .word_in  (num_word),
    .valid    (div_valid),
    .word     (div_word)
  );

  rwtm_offset u_offset (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (div_valid),
    .word_in  (div_word),
    .valid    (out_valid),
    .word     (out_word)
  );

`ifndef NO_ASSERTIONS
  // A wall pixel lies within the slice, so the rounded quotients never pass the clamp.
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    div_valid && div_word.side.kind == rwtm_pkg::KIND_WALL
      |-> div_word.row_q <= {1'b0, div_word.side.thm1})
    else $error("texel row quotient beyond texture height");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    div_valid && div_word.side.kind == rwtm_pkg::KIND_WALL
      |-> div_word.col_q <= {1'b0, div_word.side.twm1})
    else $error("texel column quotient beyond texture width");

  a_fault_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.height_fault
      |-> out_word.pixel_kind == rwtm_pkg::KIND_WALL && out_word.texel_row == 10'd0)
    else $error("height fault on a non-wall pixel or with a nonzero row");

  a_fill_only_off_wall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.pixel_kind != rwtm_pkg::KIND_WALL
      |-> out_word.texel_offset == 20'd0 && out_word.texel_texture == 2'd0)
    else $error("texel fields set on a ceiling or floor pixel");
`endif

endmodule

### rtl/core/rwtm_classify.sv
// ----------------------------------------------------------------------------
// rwtm_classify: slice edges and pixel classification
// Finds the top and bottom edges, sorts the pixel into ceiling, floor or
// wall, and picks the texture dimensions and the snapped hit fraction.
// ----------------------------------------------------------------------------
module rwtm_classify #(
  parameter int TEXTURE_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  rwtm_pkg::cfg_regs_t  cfg,
  input  logic                 valid_in,
  input  rwtm_pkg::in_word_t   word_in,
  output logic                 valid,
  output rwtm_pkg::cls_word_t  word
);

  localparam logic [2:0] TEX_LIMIT = 3'(TEXTURE_COUNT);

  logic signed [17:0] diff;
  logic signed [17:0] diff_adj;
  logic signed [17:0] top;
  logic signed [17:0] row_s;
  logic signed [17:0] rt_s;
  logic [16:0]        sum;
  logic [15:0]        bottom;
  logic               is_ceil;
  logic               is_floor;
  logic               is_wall;
  logic [1:0]         sel_sat;
  logic [10:0]        tw_raw;
  logic [10:0]        th_raw;
  logic [10:0]        tw;
  logic [10:0]        th;
  logic [13:0]        f_snap;
  rwtm_pkg::cls_word_t word_next;

  always_comb begin
    diff     = $signed({5'd0, cfg.screen_height}) - $signed({2'd0, word_in.wall_height});
    // A negative difference is bumped so halving truncates toward zero.
    diff_adj = diff + $signed({17'd0, diff[17]});
    top      = diff_adj >>> 1;
    sum      = {4'd0, cfg.screen_height} + {1'b0, word_in.wall_height};
    bottom   = sum[16:1];
    row_s    = $signed({6'd0, word_in.pixel_row});
    rt_s     = row_s - top;
    is_ceil  = row_s < top;
    is_floor = !is_ceil && ({4'd0, word_in.pixel_row} > bottom);
    is_wall  = !is_ceil && !is_floor;

    sel_sat = ({1'b0, word_in.texture_select} >= TEX_LIMIT) ? 2'(TEX_LIMIT - 3'd1)
                                                             : word_in.texture_select;
    tw_raw  = cfg.texture_widths[11*sel_sat +: 11];
    th_raw  = cfg.texture_heights[11*sel_sat +: 11];
    tw      = (tw_raw > 11'd1024) ? 11'd1024 : tw_raw;
    th      = (th_raw > 11'd1024) ? 11'd1024 : th_raw;

    if (word_in.hit_fraction < 14'd100) begin
      f_snap = 14'd0;
    end else if (word_in.hit_fraction > 14'd9900) begin
      f_snap = 14'd10000;
    end else begin
      f_snap = word_in.hit_fraction;
    end

    word_next.side.kind  = is_ceil ? rwtm_pkg::KIND_CEILING :
                           is_floor ? rwtm_pkg::KIND_FLOOR : rwtm_pkg::KIND_WALL;
    word_next.side.fill  = is_ceil ? cfg.ceiling_color :
                           is_floor ? cfg.floor_color : 24'd0;
    word_next.side.sel   = is_wall ? sel_sat : 2'd0;
    word_next.side.fault = is_wall && (word_in.wall_height == 16'd0);
    word_next.side.thm1  = (th == 11'd0) ? 10'd0 : 10'(th - 11'd1);
    word_next.side.twm1  = (tw == 11'd0) ? 10'd0 : 10'(tw - 11'd1);
    word_next.side.tw    = tw;
    word_next.rt         = rt_s[15:0];
    word_next.h          = word_in.wall_height;
    word_next.f          = f_snap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word <= word_next;
    end
  end

endmodule

### rtl/core/rwtm_numer.sv
// ----------------------------------------------------------------------------
// rwtm_numer: rounding numerators and divisors
// Multiplies the slice offset and hit fraction by the texture extents and
// forms the round-half-up dividends for both divider lanes.
// ----------------------------------------------------------------------------
module rwtm_numer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  rwtm_pkg::cls_word_t  word_in,
  output logic                 valid,
  output rwtm_pkg::num_word_t  word
);

  logic [25:0] row_prod;
  logic [23:0] col_prod;
  logic        row_live;
  rwtm_pkg::num_word_t word_next;

  always_comb begin
    row_prod = {16'd0, word_in.side.thm1} * {10'd0, word_in.rt};
    col_prod = {14'd0, word_in.side.twm1} * {10'd0, word_in.f};
    // A zero height or a non-wall pixel has a zero dividend, giving row zero.
    row_live = (word_in.side.kind == rwtm_pkg::KIND_WALL) && (word_in.h != 16'd0);

    word_next.side  = word_in.side;
    word_next.row_n = row_live ? ({row_prod, 1'b0} + {11'd0, word_in.h}) : '0;
    word_next.row_d = (word_in.h != 16'd0) ? {word_in.h, 1'b0} : 17'd2;
    word_next.col_n = col_prod + 24'd5000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word <= word_next;
    end
  end

endmodule

### rtl/core/rwtm_divider.sv
// ----------------------------------------------------------------------------
// rwtm_divider: pipelined restoring divider for the row, column alongside
// One row quotient bit per stage, most significant first, with a per-word
// divisor. The column quotient comes from a reciprocal multiply in the first
// stage and travels with the word.
// ----------------------------------------------------------------------------
module rwtm_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  rwtm_pkg::num_word_t  word_in,
  output logic                 valid,
  output rwtm_pkg::div_word_t  word
);

  localparam int QW     = rwtm_pkg::QW;
  localparam int ROW_NW = rwtm_pkg::ROW_NW;
  localparam int ROW_DW = rwtm_pkg::ROW_DW;
  localparam int COL_NW = rwtm_pkg::COL_NW;
  localparam int RW     = rwtm_pkg::COL_RECIP_W;
  localparam int PW     = COL_NW - 4 + RW;

  // The last stage keeps no remainder or divisor, so these arrays are one short.
  logic [ROW_NW-1:0]     rem_row [QW-1];
  logic [ROW_DW-1:0]     div_row [QW-1];
  logic [QW-1:0]         quo_row [QW];
  logic [QW-1:0]         quo_col [QW];
  rwtm_pkg::side_t       side    [QW];
  logic [QW-1:0]         vld;
  logic [PW-1:0]         col_scaled;
  logic [QW-1:0]         col_quo;

  // Dividing by 10000 drops the low four bits and then divides by 625.
  always_comb begin
    col_scaled = {{RW{1'b0}}, word_in.col_n[COL_NW-1:4]}
                 * {{(COL_NW - 4){1'b0}}, rwtm_pkg::COL_RECIP};
    col_quo    = col_scaled[rwtm_pkg::COL_SHIFT +: QW];
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int SH = QW - 1 - s;

    logic [ROW_NW-1:0] r_in;
    logic [ROW_DW-1:0] d_in;
    logic [QW-1:0]     qr_in;
    logic [QW-1:0]     qc_in;
    rwtm_pkg::side_t   sd_in;
    logic              v_in;
    logic [ROW_NW:0]   dsh_row;
    logic              take_row;
    logic [ROW_NW-1:0] r_next;
    logic [QW-1:0]     qr_next;

    if (s == 0) begin : g_first
      assign r_in  = word_in.row_n;
      assign d_in  = word_in.row_d;
      assign qr_in = '0;
      assign qc_in = col_quo;
      assign sd_in = word_in.side;
      assign v_in  = valid_in;
    end else begin : g_rest
      assign r_in  = rem_row[s-1];
      assign d_in  = div_row[s-1];
      assign qr_in = quo_row[s-1];
      assign qc_in = quo_col[s-1];
      assign sd_in = side[s-1];
      assign v_in  = vld[s-1];
    end

    always_comb begin
      dsh_row  = {{(ROW_NW + 1 - ROW_DW){1'b0}}, d_in} << SH;
      take_row = {1'b0, r_in} >= dsh_row;
      r_next   = take_row ? (r_in - dsh_row[ROW_NW-1:0]) : r_in;
      qr_next     = qr_in;
      qr_next[SH] = take_row;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_row[s] <= qr_next;
        quo_col[s] <= qc_in;
        side[s]    <= sd_in;
      end
    end

    if (s < QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_row[s] <= r_next;
          div_row[s] <= d_in;
        end
      end
    end
  end

  assign valid      = vld[QW-1];
  assign word.side  = side[QW-1];
  assign word.row_q = quo_row[QW-1];
  assign word.col_q = quo_col[QW-1];

endmodule

### rtl/core/rwtm_offset.sv
// ----------------------------------------------------------------------------
// rwtm_offset: clamp, linear offset and result register
// Clamps the texel coordinates to the texture, multiplies the row by the
// width, then adds the column and builds the result word.
// ----------------------------------------------------------------------------
module rwtm_offset (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  rwtm_pkg::div_word_t  word_in,
  output logic                 valid,
  output rwtm_pkg::out_word_t  word
);

  logic [9:0]      row_c;
  logic [9:0]      col_c;
  logic            mul_valid;
  rwtm_pkg::side_t mul_side;
  logic [9:0]      mul_row;
  logic [9:0]      mul_col;
  logic [20:0]     mul_prod;
  logic            is_wall;
  rwtm_pkg::out_word_t word_next;

  always_comb begin
    row_c = (word_in.row_q > {1'b0, word_in.side.thm1}) ? word_in.side.thm1
                                                         : word_in.row_q[9:0];
    col_c = (word_in.col_q > {1'b0, word_in.side.twm1}) ? word_in.side.twm1
                                                         : word_in.col_q[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_side <= word_in.side;
      mul_row  <= row_c;
      mul_col  <= col_c;
      mul_prod <= {11'd0, row_c} * {10'd0, word_in.side.tw};
    end
  end

  always_comb begin
    is_wall = (mul_side.kind == rwtm_pkg::KIND_WALL);
    word_next.pixel_kind    = mul_side.kind;
    word_next.fill_color    = mul_side.fill;
    word_next.texel_texture = mul_side.sel;
    word_next.texel_row     = is_wall ? mul_row : 10'd0;
    word_next.texel_column  = is_wall ? mul_col : 10'd0;
    word_next.texel_offset  = is_wall ? (mul_prod[19:0] + {10'd0, mul_col}) : 20'd0;
    word_next.height_fault  = mul_side.fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word <= word_next;
    end
  end

endmodule

### verif/rwtm_texel_check.sv
// ----------------------------------------------------------------------------
// rwtm_texel_check: result checker for the wall texel mapper
// Watches the configuration port and both word channels. It keeps its own copy
// of the registers, predicts each pixel's result as the input word is taken,
// and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module rwtm_texel_check #(
  parameter int TEXTURE_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [43:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rwtm_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rwtm_pkg::out_word_t out_word,
  output int                  mismatches,
  output int                  texels_due
);

  logic [12:0] scr_height;
  logic [23:0] ceil_rgb;
  logic [23:0] floor_rgb;
  logic [43:0] tex_widths;
  logic [43:0] tex_heights;

  rwtm_pkg::out_word_t mapped_pixels[$];
  rwtm_pkg::out_word_t want;

  // Sizes above 1024 are treated as 1024 so row, column and offset fit.
  function automatic longint unsigned texture_dim(logic [43:0] dims, logic [1:0] idx);
    longint unsigned d;
    d = 64'((dims >> (11 * idx)) & 44'h7FF);
    if (d > 1024) d = 1024;
    return d;
  endfunction

  function automatic rwtm_pkg::out_word_t map_pixel(rwtm_pkg::in_word_t px);
    rwtm_pkg::out_word_t res;
    longint r, h, hs, top_edge, bot_edge;
    longint unsigned tw, th, span, row, col, frac;
    logic [1:0] sel;
    res = '0;
    r = longint'(px.pixel_row);
    h = longint'(px.wall_height);
    hs = longint'(scr_height);
    // Signed division truncates toward zero, which matters when the slice
    // is taller than the screen.
    top_edge = (hs - h) / 2;
    bot_edge = (hs + h) / 2;
    if (r < top_edge) begin
      res.pixel_kind = rwtm_pkg::KIND_CEILING;
      res.fill_color = ceil_rgb;
      return res;
    end
    if (r > bot_edge) begin
      res.pixel_kind = rwtm_pkg::KIND_FLOOR;
      res.fill_color = floor_rgb;
      return res;
    end
    sel = px.texture_select;
    if (sel >= TEXTURE_COUNT) sel = 2'(TEXTURE_COUNT - 1);
    tw = texture_dim(tex_widths, sel);
    th = texture_dim(tex_heights, sel);
    row = 0;
    col = 0;
    if (h == 0) begin
      res.height_fault = 1'b1;
    end else if (th > 0) begin
      span = r - top_edge;
      row = (2 * (th - 1) * span + h) / (2 * h);
      if (row > th - 1) row = th - 1;
    end
    frac = 64'(px.hit_fraction);
    if (frac < 100) frac = 0;
    else if (frac > 9900) frac = 10000;
    if (tw > 0) begin
      col = (2 * (tw - 1) * frac + 10000) / 20000;
      if (col > tw - 1) col = tw - 1;
    end
    res.pixel_kind    = rwtm_pkg::KIND_WALL;
    res.texel_texture = sel;
    res.texel_row     = row[9:0];
    res.texel_column  = col[9:0];
    res.texel_offset  = 20'(row * tw + col);
    return res;
  endfunction

  task automatic compare_field(string name, logic [23:0] exp_val, logic [23:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scr_height  = rwtm_pkg::SCREEN_HEIGHT_RESET;
      ceil_rgb    = '0;
      floor_rgb   = '0;
      tex_widths  = '0;
      tex_heights = '0;
      mapped_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (mapped_pixels.size() == 0) begin
          $error("result word arrived with no pixel waiting for it");
          mismatches++;
        end else begin
          want = mapped_pixels.pop_front();
          compare_field("pixel_kind", 24'(want.pixel_kind), 24'(out_word.pixel_kind));
          compare_field("fill_color", want.fill_color, out_word.fill_color);
          compare_field("texel_texture", 24'(want.texel_texture),
                        24'(out_word.texel_texture));
          compare_field("texel_row", 24'(want.texel_row), 24'(out_word.texel_row));
          compare_field("texel_column", 24'(want.texel_column),
                        24'(out_word.texel_column));
          compare_field("texel_offset", 24'(want.texel_offset),
                        24'(out_word.texel_offset));
          compare_field("height_fault", 24'(want.height_fault),
                        24'(out_word.height_fault));
        end
      end
      if (in_valid && in_ready) mapped_pixels.push_back(map_pixel(in_word));
      if (cfg_we) begin
        case (cfg_index)
          rwtm_pkg::REG_SCREEN_HEIGHT:   scr_height  = cfg_data[12:0];
          rwtm_pkg::REG_CEILING_COLOR:   ceil_rgb    = cfg_data[23:0];
          rwtm_pkg::REG_FLOOR_COLOR:     floor_rgb   = cfg_data[23:0];
          rwtm_pkg::REG_TEXTURE_WIDTHS:  tex_widths  = cfg_data;
          rwtm_pkg::REG_TEXTURE_HEIGHTS: tex_heights = cfg_data;
          default: ;
        endcase
      end
    end
    texels_due = mapped_pixels.size();
  end

endmodule

### verif/tb_raycast_wall_texel_mapper_core.sv
// ----------------------------------------------------------------------------
// tb_raycast_wall_texel_mapper_core: testbench for the wall texel mapper
// Drives pixel words through the mapper under several register settings,
// first a directed set of edge cases and then shaped random pixels, with
// random gaps on both channels. The checker beside the block does the
// prediction and comparison; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_raycast_wall_texel_mapper_core;

  localparam int         STALL_LIMIT = 2000;
  localparam int         TAIL_CYCLES = 20;
  localparam logic [2:0] REG_UNUSED  = 3'd5;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = rwtm_pkg::REG_SCREEN_HEIGHT;
  logic [43:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rwtm_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rwtm_pkg::out_word_t out_word;

  logic calm = 1'b0;
  int   cur_height = 480;
  int   quiet_cycles = 0;
  int   mismatches;
  int   texels_due;

  always #1 clk = ~clk;

  raycast_wall_texel_mapper_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  rwtm_texel_check i_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .mismatches (mismatches),
    .texels_due (texels_due)
  );

  // The receiver stalls about one cycle in five except during the calm phase.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_raycast_wall_texel_mapper_core: FAIL");
    $finish;
  end

  function automatic rwtm_pkg::in_word_t pixel_at(logic [11:0] r, logic [15:0] h,
                                                  logic [1:0] sel, logic [13:0] f);
    rwtm_pkg::in_word_t px;
    px.pixel_row      = r;
    px.wall_height    = h;
    px.texture_select = sel;
    px.hit_fraction   = f;
    return px;
  endfunction

  // Most pixels land near the slice edges or on the slice itself; a few are
  // fully random so every input bit gets exercised.
  function automatic rwtm_pkg::in_word_t random_pixel();
    rwtm_pkg::in_word_t px;
    int ht, top_edge, bot_edge, pos, pick;
    px.texture_select = 2'($urandom_range(3));
    pick = int'($urandom_range(99));
    if (pick < 15) begin
      px.pixel_row    = 12'($urandom);
      px.wall_height  = 16'($urandom);
      px.hit_fraction = 14'($urandom);
      return px;
    end
    case ($urandom_range(9))
      0:       ht = 0;
      1, 2:    ht = int'($urandom_range(65535));
      default: ht = int'($urandom_range(2 * cur_height + 2));
    endcase
    if (ht > 65535) ht = 65535;
    top_edge = (cur_height - ht) / 2;
    bot_edge = (cur_height + ht) / 2;
    if (pick < 45)
      pos = (pick[0] ? top_edge : bot_edge) + int'($urandom_range(4)) - 2;
    else
      pos = top_edge - 2 + int'($urandom_range(bot_edge - top_edge + 4));
    if (pos < 0) pos = 0;
    if (pos > 4095) pos = 4095;
    px.pixel_row   = 12'(pos);
    px.wall_height = 16'(ht);
    case ($urandom_range(11))
      0: px.hit_fraction = 14'd99;
      1: px.hit_fraction = 14'd100;
      2: px.hit_fraction = 14'd9900;
      3: px.hit_fraction = 14'd9901;
      4: px.hit_fraction = 14'($urandom_range(10001, 16383));
      default: px.hit_fraction = 14'($urandom_range(10000));
    endcase
    return px;
  endfunction

  task automatic offer_pixel(input rwtm_pkg::in_word_t px);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_pixels(input int count);
    repeat (count) offer_pixel(random_pixel());
  endtask

  // Every word yields one result, so the block is idle once none is owed.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (texels_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [43:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [12:0] height, input logic [23:0] ceil_rgb,
                              input logic [23:0] floor_rgb, input logic [43:0] widths,
                              input logic [43:0] heights);
    // A write to an index past the register list must change nothing.
    write_reg(REG_UNUSED, 44'({$urandom, $urandom}));
    write_reg(rwtm_pkg::REG_SCREEN_HEIGHT, 44'(height));
    write_reg(rwtm_pkg::REG_CEILING_COLOR, 44'(ceil_rgb));
    write_reg(rwtm_pkg::REG_FLOOR_COLOR, 44'(floor_rgb));
    write_reg(rwtm_pkg::REG_TEXTURE_WIDTHS, widths);
    write_reg(rwtm_pkg::REG_TEXTURE_HEIGHTS, heights);
    cfg_we <= 1'b0;
    cur_height = int'(height);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Register defaults straight out of reset.
    offer_pixel(pixel_at(12'd0, 16'd10, 2'd0, 14'd0));
    offer_pixel(pixel_at(12'd4095, 16'd10, 2'd1, 14'd5000));
    offer_pixel(pixel_at(12'd240, 16'd0, 2'd2, 14'd10000));
    offer_pixel(pixel_at(12'd240, 16'd100, 2'd3, 14'd7000));
    wait_drained();

    // Texture 2 is wider than 1024, texture 3 is one column wide with no rows.
    program_regs(13'd480, 24'h123456, 24'hABCDEF,
                 {11'd1, 11'd2047, 11'd1024, 11'd64},
                 {11'd0, 11'd1024, 11'd2047, 11'd64});
    offer_pixel(pixel_at(12'd0, 16'd100, 2'd0, 14'd5000));
    offer_pixel(pixel_at(12'd4095, 16'd100, 2'd0, 14'd5000));
    offer_pixel(pixel_at(12'd189, 16'd100, 2'd0, 14'd5000));
    offer_pixel(pixel_at(12'd190, 16'd100, 2'd0, 14'd5000));
    offer_pixel(pixel_at(12'd290, 16'd100, 2'd0, 14'd5000));
    offer_pixel(pixel_at(12'd291, 16'd100, 2'd0, 14'd5000));
    offer_pixel(pixel_at(12'd239, 16'd0, 2'd1, 14'd5000));
    offer_pixel(pixel_at(12'd240, 16'd0, 2'd1, 14'd5000));
    offer_pixel(pixel_at(12'd241, 16'd0, 2'd1, 14'd5000));
    offer_pixel(pixel_at(12'd0, 16'd481, 2'd0, 14'd0));
    offer_pixel(pixel_at(12'd0, 16'd65535, 2'd1, 14'd50));
    offer_pixel(pixel_at(12'd4095, 16'd65535, 2'd1, 14'd16383));
    offer_pixel(pixel_at(12'd2000, 16'd65535, 2'd2, 14'd99));
    offer_pixel(pixel_at(12'd2000, 16'd65535, 2'd2, 14'd100));
    offer_pixel(pixel_at(12'd2000, 16'd65535, 2'd3, 14'd9900));
    offer_pixel(pixel_at(12'd2000, 16'd65535, 2'd3, 14'd9901));
    offer_pixel(pixel_at(12'd2000, 16'd65535, 2'd0, 14'd10000));
    offer_pixel(pixel_at(12'd4095, 16'd4095, 2'd1, 14'd10000));
    offer_pixel(pixel_at(12'd240, 16'd1, 2'd0, 14'd3));
    offer_pixel(pixel_at(12'd4095, 16'd65535, 2'd2, 14'd1));
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_regs(13'd4096, 24'hFFFFFF, 24'h000000, {44{1'b1}}, {44{1'b1}});
        1: program_regs(13'd1, 24'h000000, 24'hFFFFFF, '0, '0);
        2: program_regs(13'd0, 24'($urandom), 24'($urandom), 44'({$urandom, $urandom}),
                        44'({$urandom, $urandom}));
        3: program_regs(13'd8191, 24'($urandom), 24'($urandom),
                        44'({$urandom, $urandom}), 44'({$urandom, $urandom}));
        4: program_regs(13'($urandom_range(1, 4096)), 24'($urandom), 24'($urandom),
                        44'({$urandom, $urandom}), 44'({$urandom, $urandom}));
        default: program_regs(13'd480, 24'($urandom), 24'($urandom),
                              {11'd1025, 11'd1023, 11'd2, 11'd1},
                              {11'd1, 11'd2, 11'd1023, 11'd1025});
      endcase
      // One whole phase runs with neither side idling.
      calm <= (ph == 2);
      random_pixels(140);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && texels_due == 0)
      $display("tb_raycast_wall_texel_mapper_core: PASS");
    else
      $display("tb_raycast_wall_texel_mapper_core: FAIL");
    $finish;
  end

endmodule

### raycast_wall_texel_mapper_core.f
rtl/core/rwtm_pkg.sv
rtl/core/rwtm_classify.sv
rtl/core/rwtm_numer.sv
rtl/core/rwtm_divider.sv
rtl/core/rwtm_offset.sv
rtl/core/raycast_wall_texel_mapper_core.sv
verif/rwtm_texel_check.sv
verif/tb_raycast_wall_texel_mapper_core.sv
